@@ rtl/rtx_pkg.sv @@
// ----------------------------------------------------------------------------
// rtx_pkg: shared constants and helpers for the xterm 256-color quantizer
// Cube levels, palette bases and the fixed-point reciprocals used in place
// of the divisions by 3 and by 10.
// ----------------------------------------------------------------------------
package rtx_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned LevelW = 3;
  localparam int unsigned StepW  = 5;
  localparam int unsigned SumW   = 10;
  localparam int unsigned SqW    = 2 * ChanW;
  localparam int unsigned DistW  = SqW + 2;

  localparam logic [7:0] CubeBase    = 8'd16;
  localparam logic [7:0] GrayBase    = 8'd232;
  localparam logic [StepW-1:0] GrayMaxStep = 5'd23;
  localparam logic [7:0] GrayOffset  = 8'd8;
  localparam logic [7:0] AvgBias     = 8'd3;

  // floor(s/3) == (s*683) >> 11 for s up to 765.
  localparam logic [SumW-1:0] Recip3  = 10'd683;
  localparam int unsigned     Recip3Sh = 11;
  // floor(x/10) == (x*205) >> 11 for x up to 252.
  localparam logic [ChanW-1:0] Recip10 = 8'd205;
  localparam int unsigned      Recip10Sh = 11;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [LevelW-1:0] level_t;
  typedef logic [DistW-1:0]  dist_t;

  // Nearest cube level; a value exactly halfway goes to the lower level.
  function automatic level_t snap_level(input chan_t v);
    level_t k;
    priority if (v <= 8'd47)  k = 3'd0;
    else if (v <= 8'd115)     k = 3'd1;
    else if (v <= 8'd155)     k = 3'd2;
    else if (v <= 8'd195)     k = 3'd3;
    else if (v <= 8'd235)     k = 3'd4;
    else                      k = 3'd5;
    return k;
  endfunction

  function automatic chan_t cube_level(input level_t k);
    chan_t lv;
    unique case (k)
      3'd0:    lv = 8'd0;
      3'd1:    lv = 8'd95;
      3'd2:    lv = 8'd135;
      3'd3:    lv = 8'd175;
      3'd4:    lv = 8'd215;
      default: lv = 8'd255;
    endcase
    return lv;
  endfunction

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic dist_t sum_sq(input chan_t a, input chan_t b, input chan_t c);
    logic [SqW-1:0] sa, sb, sc;
    sa = a * a;
    sb = b * b;
    sc = c * c;
    return DistW'(sa) + DistW'(sb) + DistW'(sc);
  endfunction

endpackage

@@ rtl/rgb_to_xterm256_index_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_xterm256_index_core: RGB pixel to xterm 256-color palette index
// Five-stage pipeline: snap and sum, average, gray step and cube distance,
// gray differences, gray distance and final select.
// An accepted request moves through stages 1 to 4 and then sets out_valid; one
// pixel is accepted per clock while the output register is free or drained.
// The whole pipeline stalls as one when the output register holds a result
// that is not taken. Synchronous active-low reset clears all valid bits.
// ----------------------------------------------------------------------------
module rgb_to_xterm256_index_core
  import rtx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_palette_index
);

  logic adv;

  // Stage 1: snapped levels and channel sum.
  logic v1_r;
  chan_t r1_r, g1_r, b1_r;
  level_t ri1_r, gi1_r, bi1_r;
  logic [SumW-1:0] sum1_r;

  // Stage 2: average and cube differences.
  logic v2_r;
  chan_t r2_r, g2_r, b2_r;
  level_t ri2_r, gi2_r, bi2_r;
  chan_t avg2_r;
  chan_t cdr2_r, cdg2_r, cdb2_r;

  // Stage 3: gray step, cube distance and cube index.
  logic v3_r;
  chan_t r3_r, g3_r, b3_r;
  logic [StepW-1:0] step3_r;
  dist_t cdist3_r;
  logic [7:0] cidx3_r;

  // Stage 4: gray differences.
  logic v4_r;
  logic [StepW-1:0] step4_r;
  dist_t cdist4_r;
  logic [7:0] cidx4_r;
  chan_t gdr4_r, gdg4_r, gdb4_r;

  // Stage 5: output register.
  logic out_valid_r;
  logic [7:0] idx5_r;

  logic [2*SumW-1:0]  avg_prod;
  chan_t              avg_m3;
  logic [2*ChanW-1:0] step_prod;
  logic [StepW-1:0]   step_raw;
  logic [StepW-1:0]   step_nxt;
  logic [7:0]         cidx_nxt;
  chan_t              gray_val;
  dist_t              gdist;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign avg_prod  = sum1_r * SumW'(Recip3);
  assign avg_m3    = avg2_r - AvgBias;
  assign step_prod = avg_m3 * Recip10;
  assign step_raw  = step_prod[Recip10Sh +: StepW];

  always_comb begin
    if (avg2_r < AvgBias) begin
      step_nxt = '0;
    end else if (step_raw > GrayMaxStep) begin
      step_nxt = GrayMaxStep;
    end else begin
      step_nxt = step_raw;
    end
  end

  // 36*ri + 6*gi + bi stays below 216, so eight bits hold the sum with the base.
  assign cidx_nxt = CubeBase + ({5'd0, ri2_r} << 5) + ({5'd0, ri2_r} << 2)
                  + ({5'd0, gi2_r} << 2) + ({5'd0, gi2_r} << 1) + {5'd0, bi2_r};

  assign gray_val = GrayOffset + ({3'd0, step3_r} << 3) + ({3'd0, step3_r} << 1);
  assign gdist    = sum_sq(gdr4_r, gdg4_r, gdb4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_r   <= in_red;
      g1_r   <= in_green;
      b1_r   <= in_blue;
      ri1_r  <= snap_level(in_red);
      gi1_r  <= snap_level(in_green);
      bi1_r  <= snap_level(in_blue);
      sum1_r <= SumW'(in_red) + SumW'(in_green) + SumW'(in_blue);

      r2_r   <= r1_r;
      g2_r   <= g1_r;
      b2_r   <= b1_r;
      ri2_r  <= ri1_r;
      gi2_r  <= gi1_r;
      bi2_r  <= bi1_r;
      avg2_r <= avg_prod[Recip3Sh +: ChanW];
      cdr2_r <= abs_diff(r1_r, cube_level(ri1_r));
      cdg2_r <= abs_diff(g1_r, cube_level(gi1_r));
      cdb2_r <= abs_diff(b1_r, cube_level(bi1_r));

      r3_r     <= r2_r;
      g3_r     <= g2_r;
      b3_r     <= b2_r;
      step3_r  <= step_nxt;
      cdist3_r <= sum_sq(cdr2_r, cdg2_r, cdb2_r);
      cidx3_r  <= cidx_nxt;

      step4_r  <= step3_r;
      cdist4_r <= cdist3_r;
      cidx4_r  <= cidx3_r;
      gdr4_r   <= abs_diff(r3_r, gray_val);
      gdg4_r   <= abs_diff(g3_r, gray_val);
      gdb4_r   <= abs_diff(b3_r, gray_val);

      // Gray wins only when strictly nearer.
      idx5_r <= (gdist < cdist4_r) ? (GrayBase + {3'd0, step4_r}) : cidx4_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = idx5_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (step3_r <= GrayMaxStep))
    else $error("gray step out of range");

  a_index_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (idx5_r >= CubeBase))
    else $error("palette index below cube base");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r && !v4_r && !out_valid_r))
    else $error("valid bits not cleared by reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !adv) |=> v4_r)
    else $error("pipeline item lost during stall");

endmodule

@@ test/xterm_index_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xterm_index_checker: result checker for the RGB to xterm-256 quantizer
// Watches the pixel and palette index channels. Every accepted pixel request
// is turned into the palette index that it should map to, and every accepted
// result is compared against the oldest index still outstanding.
// ----------------------------------------------------------------------------
module xterm_index_checker
  import rtx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_palette_index,
  output int         mismatch_count,
  output int         pending_count
);

  localparam logic [5:0][7:0] CubeLevel = {
    8'd255, 8'd215, 8'd175, 8'd135, 8'd95, 8'd0
  };

  logic [7:0] expected_index_q [$];
  int         mismatch_tally;

  function automatic int square_gap(input int a, input int b);
    return (a - b) * (a - b);
  endfunction

  // Index of the closest cube level; on a tie the lower level is kept.
  function automatic int closest_level(input chan_t v);
    int best;
    int best_gap;
    int gap;
    best     = 0;
    best_gap = 1 << 20;
    for (int k = 0; k < 6; k++) begin
      gap = square_gap(int'(v), int'(CubeLevel[k]));
      if (gap < best_gap) begin
        best_gap = gap;
        best     = k;
      end
    end
    return best;
  endfunction

  function automatic logic [7:0] nearest_xterm_index(input chan_t r, input chan_t g,
                                                    input chan_t b);
    int ri, gi, bi;
    int cube_dist, gray_dist;
    int avg, step, gray;
    ri = closest_level(r);
    gi = closest_level(g);
    bi = closest_level(b);
    cube_dist = square_gap(int'(r), int'(CubeLevel[ri]))
              + square_gap(int'(g), int'(CubeLevel[gi]))
              + square_gap(int'(b), int'(CubeLevel[bi]));
    avg  = (int'(r) + int'(g) + int'(b)) / 3;
    step = (avg < 3) ? 0 : (avg - 3) / 10;
    if (step > int'(GrayMaxStep)) begin
      step = int'(GrayMaxStep);
    end
    gray      = 8 + 10 * step;
    gray_dist = square_gap(int'(r), gray) + square_gap(int'(g), gray)
              + square_gap(int'(b), gray);
    // The gray ramp only wins when it is strictly closer than the cube.
    if (gray_dist < cube_dist) begin
      return 8'(int'(GrayBase) + step);
    end
    return 8'(int'(CubeBase) + 36 * ri + 6 * gi + bi);
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_index_q.size() == 0) begin
          $display("%0t: result with no pixel outstanding: expected none, actual %0d",
                   $time, out_palette_index);
          mismatch_tally++;
        end else begin
          want = expected_index_q.pop_front();
          if (out_palette_index !== want) begin
            $display("%0t: palette_index mismatch: expected %0d, actual %0d",
                     $time, want, out_palette_index);
            mismatch_tally++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_index_q.push_back(nearest_xterm_index(in_red, in_green, in_blue));
      end
    end
    mismatch_count <= mismatch_tally;
    pending_count  <= expected_index_q.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rgb_to_xterm256_index_core
// Sends directed corner pixels followed by random pixels (uniform, near-gray,
// near cube boundaries and exact cube colors) in bursts with random gaps,
// while the result side stalls in changing patterns. Checking is done by
// xterm_index_checker; this module drives requests and reports the verdict.
// ----------------------------------------------------------------------------
module tb
  import rtx_pkg::*;
();

  localparam int RandomPixels = 1830;
  localparam int LongHold     = 120;
  localparam int StallLimit   = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_palette_index;
  int         mismatch_count;
  int         pending_count;
  int         hold_request;
  int         quiet_cycles;

  rgb_to_xterm256_index_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_palette_index (out_palette_index)
  );

  xterm_index_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_palette_index (out_palette_index),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one pixel and returns at the edge where the request is taken.
  task automatic push_pixel(input chan_t r, input chan_t g, input chan_t b);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic chan_t jitter(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  function automatic chan_t boundary_value();
    int pick;
    case ($urandom_range(0, 5))
      0:       pick = 47;
      1:       pick = 115;
      2:       pick = 155;
      3:       pick = 195;
      4:       pick = 235;
      default: pick = 4;
    endcase
    return jitter(pick, 2);
  endfunction

  function automatic chan_t cube_value();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd95;
      2:       return 8'd135;
      3:       return 8'd175;
      4:       return 8'd215;
      default: return 8'd255;
    endcase
  endfunction

  task automatic random_pixel(output chan_t r, output chan_t g, output chan_t b);
    int base;
    base = $urandom_range(0, 255);
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
      end
      3, 4: begin
        // Near-gray pixels are where the gray ramp and the cube compete.
        r = jitter(base, 6);
        g = jitter(base, 6);
        b = jitter(base, 6);
      end
      5: begin
        r = boundary_value();
        g = boundary_value();
        b = boundary_value();
      end
      6: begin
        r = cube_value();
        g = cube_value();
        b = cube_value();
      end
      default: begin
        r = jitter(base, 1);
        g = jitter(base, 1);
        b = jitter(base, 1);
      end
    endcase
  endtask

  // Result side: a stall pattern that rotates through four ready patterns, plus a long
  // hold-off whenever the request side asks for one.
  initial begin : receiver
    int hold_seen;
    int rx_cycle;
    hold_seen = 0;
    rx_cycle  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(posedge clk);
      end else begin
        case ((rx_cycle / 97) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((rx_cycle % 5) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    chan_t r, g, b;
    int    sent;
    int    burst;
    bit    hold_done;
    bit    pause_done;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_red       <= 8'd0;
    in_green     <= 8'd0;
    in_blue      <= 8'd0;
    hold_request <= 0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners, cube ties that go to the lower level, equal cube and gray
    // distances, averages below three and the clamped top gray step.
    push_pixel(8'd0,   8'd0,   8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0,   8'd0);
    push_pixel(8'd0,   8'd255, 8'd0);
    push_pixel(8'd0,   8'd0,   8'd255);
    push_pixel(8'd47,  8'd48,  8'd115);
    push_pixel(8'd116, 8'd155, 8'd156);
    push_pixel(8'd195, 8'd196, 8'd235);
    push_pixel(8'd236, 8'd95,  8'd135);
    push_pixel(8'd4,   8'd4,   8'd4);
    push_pixel(8'd5,   8'd4,   8'd3);
    push_pixel(8'd2,   8'd2,   8'd2);
    push_pixel(8'd0,   8'd0,   8'd8);
    push_pixel(8'd250, 8'd250, 8'd250);
    push_pixel(8'd238, 8'd238, 8'd238);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd8,   8'd8,   8'd8);
    push_pixel(8'd18,  8'd20,  8'd16);
    push_pixel(8'd95,  8'd135, 8'd175);
    push_pixel(8'd215, 8'd0,   8'd255);
    push_pixel(8'd100, 8'd100, 8'd100);
    push_pixel(8'd170, 8'd85,  8'd240);
    push_pixel(8'd127, 8'd128, 8'd1);
    drain_results();

    sent = 0;
    while (sent < RandomPixels) begin
      if (!hold_done && sent >= 600) begin
        // Block the result side and offer 40 more requests, so that the input stalls.
        hold_done = 1'b1;
        hold_request <= hold_request + 1;
        repeat (40) begin
          random_pixel(r, g, b);
          push_pixel(r, g, b);
          sent++;
        end
      end else if (!pause_done && sent >= 1200) begin
        pause_done = 1'b1;
        drain_results();
      end
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        random_pixel(r, g, b);
        push_pixel(r, g, b);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 8));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rtx_pkg.sv
rtl/rgb_to_xterm256_index_core.sv
test/xterm_index_checker.sv
test/tb.sv
